// File: design/cbb_pkg.sv
package cbb_pkg;

    localparam int MAX_DEGREE = 7;

    localparam int DEN_W = 64;
    localparam int QUO_W = 59;
    localparam int CNT_W = 6;

    localparam logic [CNT_W-1:0] RECIP_STEPS  = CNT_W'(QUO_W);
    localparam logic [CNT_W-1:0] WEIGHT_STEPS = CNT_W'(48);

    localparam logic signed [47:0] ONE_Q28 = 48'sd268435456;
    localparam logic [47:0] POS_CAP = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_CAP = 48'h8000_0000_0000;

    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] rem0;
        logic [QUO_W-1:0] low;
        logic [CNT_W-1:0] count;
        logic [DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quo;
    } t_div_rsp;

    // Chebyshev extreme points cos(pi*i/d) in signed Q2.30
    function automatic logic signed [31:0] cos_q30(input logic [2:0] d, input logic [2:0] i);
        logic signed [31:0] v;
        v = 32'sd0;
        unique case (d)
            3'd1: case (i)
                3'd0: v = 32'sd1073741824;
                3'd1: v = -32'sd1073741824;
                default: v = 32'sd0;
            endcase
            3'd2: case (i)
                3'd0: v = 32'sd1073741824;
                3'd2: v = -32'sd1073741824;
                default: v = 32'sd0;
            endcase
            3'd3: case (i)
                3'd0: v = 32'sd1073741824;
                3'd1: v = 32'sd536870912;
                3'd2: v = -32'sd536870912;
                3'd3: v = -32'sd1073741824;
                default: v = 32'sd0;
            endcase
            3'd4: case (i)
                3'd0: v = 32'sd1073741824;
                3'd1: v = 32'sd759250125;
                3'd3: v = -32'sd759250125;
                3'd4: v = -32'sd1073741824;
                default: v = 32'sd0;
            endcase
            3'd5: case (i)
                3'd0: v = 32'sd1073741824;
                3'd1: v = 32'sd868675383;
                3'd2: v = 32'sd331804471;
                3'd3: v = -32'sd331804471;
                3'd4: v = -32'sd868675383;
                3'd5: v = -32'sd1073741824;
                default: v = 32'sd0;
            endcase
            3'd6: case (i)
                3'd0: v = 32'sd1073741824;
                3'd1: v = 32'sd929887697;
                3'd2: v = 32'sd536870912;
                3'd4: v = -32'sd536870912;
                3'd5: v = -32'sd929887697;
                3'd6: v = -32'sd1073741824;
                default: v = 32'sd0;
            endcase
            3'd7: case (i)
                3'd0: v = 32'sd1073741824;
                3'd1: v = 32'sd967407956;
                3'd2: v = 32'sd669467077;
                3'd3: v = 32'sd238930034;
                3'd4: v = -32'sd238930034;
                3'd5: v = -32'sd669467077;
                3'd6: v = -32'sd967407956;
                default: v = -32'sd1073741824;
            endcase
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

endpackage

// File: design/cbb_div.sv
// Restoring divider, one quotient bit per cycle.
module cbb_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cbb_pkg::t_div_req i_req,
    output cbb_pkg::t_div_rsp o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [cbb_pkg::DEN_W-1:0]   r_rem;
    logic [cbb_pkg::DEN_W-1:0]   r_den;
    logic [cbb_pkg::QUO_W-1:0]   r_low;
    logic [cbb_pkg::QUO_W-1:0]   r_quo;
    logic [cbb_pkg::CNT_W-1:0]   r_cnt;

    logic [cbb_pkg::DEN_W:0]     trial;
    logic                        fits;

    assign trial = {r_rem, r_low[cbb_pkg::QUO_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_rem  <= i_req.rem0;
                r_den  <= i_req.den;
                r_low  <= i_req.low;
                r_cnt  <= i_req.count;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= fits ? cbb_pkg::DEN_W'(trial - {1'b0, r_den})
                              : trial[cbb_pkg::DEN_W-1:0];
                r_quo <= {r_quo[cbb_pkg::QUO_W-2:0], fits};
                r_low <= {r_low[cbb_pkg::QUO_W-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == cbb_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// File: design/chebyshev_barycentric_basis_2d_core.sv
// Two-dimensional barycentric Lagrange basis on Chebyshev extreme points. Write the
// degree (0..7, reset 1) through the config channel while idle, then hand in one item:
// a point and its cell bounds, all signed Q3.28. The block returns (degree+1)^2 items,
// basis values in signed Q19.28 saturated to 48 bits, row-major (xi node outer, eta node
// inner), with last set on the final one. Only one point is in flight; input ready is
// high only while idle. Cost per point is set by the single restoring divider, one
// quotient bit per cycle: per axis, degree+1 reciprocals of 59 steps and up to degree+1
// normalizations of 48 steps, all skipped when the point sits on a node; then each
// result item is held until taken. Degree 0 uses no division.
module chebyshev_barycentric_basis_2d_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_degree,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_point_xi,
    input  logic signed [31:0] i_point_eta,
    input  logic signed [31:0] i_xi_lower,
    input  logic signed [31:0] i_xi_upper,
    input  logic signed [31:0] i_eta_lower,
    input  logic signed [31:0] i_eta_upper,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [47:0] o_basis_value,
    output logic [2:0]         o_xi_node,
    output logic [2:0]         o_eta_node,
    output logic               o_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_AXIS, S_NODE_MUL, S_NODE_ADD, S_HIT, S_RECIP, S_RECIP_WAIT,
        S_WEIGHT, S_WEIGHT_WAIT, S_READ, S_MUL_LO, S_MUL_HI, S_SUM, S_OUT
    } t_state;

    t_state r_state;

    logic [2:0] r_degree;
    logic [2:0] r_d;
    logic [2:0] r_i;
    logic [2:0] r_j;
    logic       r_axis;

    logic signed [31:0] r_xi, r_eta, r_xl, r_xu, r_el, r_eu;

    logic signed [36:0] r_dist [8];
    logic signed [59:0] r_q    [8];
    logic signed [63:0] r_sum;
    logic               r_hit;
    logic [2:0]         r_hit_idx;
    logic [63:0]        r_prod64;

    // weight stores, written from the sequencer, read in the emit loop
    logic signed [47:0] xw_mem [8];
    logic signed [47:0] ew_mem [8];
    logic               r_wr_en;
    logic               r_wr_axis;
    logic [2:0]         r_wr_addr;
    logic signed [47:0] r_wr_data;
    logic signed [47:0] r_xw_rd, r_ew_rd;

    logic [71:0] r_plo;
    logic [71:0] r_phi;
    logic        r_pneg;

    cbb_pkg::t_div_req r_div_req;
    cbb_pkg::t_div_rsp div_rsp;

    logic               r_out_valid;
    logic signed [47:0] r_out_value;
    logic [2:0]         r_out_xi, r_out_eta;
    logic               r_out_last;

    cbb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .o_rsp   (div_rsp)
    );

    // ---- per-axis operand selection ----
    logic signed [31:0] ax_x, ax_lo, ax_hi;
    logic signed [32:0] span, base;
    logic [32:0]        mspan;
    logic signed [31:0] cval;
    logic [30:0]        mcos;
    logic [63:0]        rounded;
    logic [33:0]        mscaled;
    logic signed [35:0] scaled;
    logic signed [36:0] node_dist;
    logic [2:0]         d_eff;

    assign d_eff   = (i_cfg_degree > 3'(cbb_pkg::MAX_DEGREE)) ? 3'(cbb_pkg::MAX_DEGREE)
                                                               : i_cfg_degree;
    assign ax_x    = r_axis ? r_eta : r_xi;
    assign ax_lo   = r_axis ? r_el  : r_xl;
    assign ax_hi   = r_axis ? r_eu  : r_xu;
    assign span    = {ax_hi[31], ax_hi} - {ax_lo[31], ax_lo};
    assign base    = {ax_hi[31], ax_hi} + {ax_lo[31], ax_lo};
    assign mspan   = span[32] ? 33'(-span) : 33'(span);
    assign cval    = cbb_pkg::cos_q30(r_d, r_i);
    assign mcos    = cval[31] ? 31'(-cval) : cval[30:0];
    assign rounded = r_prod64 + 64'(1) * (64'd1 << 29);
    assign mscaled = rounded[63:30];
    assign scaled  = (cval[31] ^ span[32]) ? -$signed({2'b00, mscaled})
                                           : $signed({2'b00, mscaled});
    assign node_dist = $signed({ax_x[31], ax_x[31], ax_x[31], ax_x[31], ax_x, 1'b0})
                     - $signed({{4{base[32]}}, base})
                     - $signed({scaled[35], scaled});

    // ---- reciprocal and normalization operands ----
    logic signed [36:0] cur_dist;
    logic [36:0]        mdist;
    logic               recip_end;
    logic               recip_neg;
    logic signed [59:0] qval;
    logic signed [59:0] cur_q;
    logic [58:0]        mq;
    logic [63:0]        msum;
    logic               wneg;
    logic [47:0]        wcap;
    logic [47:0]        wq;

    assign cur_dist  = r_dist[r_i];
    assign mdist     = cur_dist[36] ? 37'(-cur_dist) : 37'(cur_dist);
    assign recip_end = (r_i == 3'd0) || (r_i == r_d);
    assign recip_neg = r_i[0] ^ cur_dist[36];
    assign qval      = recip_neg ? -$signed({1'b0, div_rsp.quo}) : $signed({1'b0, div_rsp.quo});
    assign cur_q     = r_q[r_i];
    assign mq        = cur_q[59] ? 59'(-cur_q) : cur_q[58:0];
    assign msum      = r_sum[63] ? 64'(-r_sum) : 64'(r_sum);
    assign wneg      = cur_q[59] ^ r_sum[63];
    assign wcap      = wneg ? cbb_pkg::NEG_CAP : cbb_pkg::POS_CAP;
    assign wq        = (div_rsp.quo[47:0] > wcap) ? wcap : div_rsp.quo[47:0];

    // ---- product operands ----
    logic [47:0] ma, mb;
    logic [95:0] prod;
    logic [67:0] pshift;
    logic [47:0] pcap;
    logic [47:0] pmag;

    assign ma     = r_xw_rd[47] ? 48'(-r_xw_rd) : 48'(r_xw_rd);
    assign mb     = r_ew_rd[47] ? 48'(-r_ew_rd) : 48'(r_ew_rd);
    assign prod   = {24'b0, r_plo} + {r_phi, 24'b0};
    assign pshift = prod[95:28];
    assign pcap   = r_pneg ? cbb_pkg::NEG_CAP : cbb_pkg::POS_CAP;
    assign pmag   = (pshift > {20'b0, pcap}) ? pcap : pshift[47:0];

    // weight stores
    always_ff @(posedge i_clk) begin
        if (r_wr_en && !r_wr_axis) begin
            xw_mem[r_wr_addr] <= r_wr_data;
        end
        r_xw_rd <= xw_mem[r_i];
    end

    always_ff @(posedge i_clk) begin
        if (r_wr_en && r_wr_axis) begin
            ew_mem[r_wr_addr] <= r_wr_data;
        end
        r_ew_rd <= ew_mem[r_j];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_degree        <= 3'd1;
            r_out_valid     <= 1'b0;
            r_wr_en         <= 1'b0;
            r_div_req.start <= 1'b0;
            r_i             <= '0;
            r_j             <= '0;
            r_axis          <= 1'b0;
        end else begin
            r_wr_en         <= 1'b0;
            r_div_req.start <= 1'b0;
            if (i_cfg_valid) begin
                r_degree <= d_eff;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_xi    <= i_point_xi;
                        r_eta   <= i_point_eta;
                        r_xl    <= i_xi_lower;
                        r_xu    <= i_xi_upper;
                        r_el    <= i_eta_lower;
                        r_eu    <= i_eta_upper;
                        r_d     <= r_degree;
                        r_axis  <= 1'b0;
                        r_state <= S_AXIS;
                    end
                end
                S_AXIS: begin
                    r_i   <= '0;
                    r_hit <= 1'b0;
                    r_sum <= '0;
                    if (r_d == 3'd0) begin
                        // degree zero: the single weight is one
                        r_wr_en   <= 1'b1;
                        r_wr_axis <= r_axis;
                        r_wr_addr <= 3'd0;
                        r_wr_data <= cbb_pkg::ONE_Q28;
                        if (!r_axis) begin
                            r_axis <= 1'b1;
                        end else begin
                            r_j     <= '0;
                            r_state <= S_READ;
                        end
                    end else begin
                        r_state <= S_NODE_MUL;
                    end
                end
                S_NODE_MUL: begin
                    r_prod64 <= 64'(mcos) * 64'(mspan);
                    r_state  <= S_NODE_ADD;
                end
                S_NODE_ADD: begin
                    r_dist[r_i] <= node_dist;
                    if (node_dist == '0 && !r_hit) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_i;
                    end
                    if (r_i == r_d) begin
                        r_i     <= '0;
                        r_state <= (r_hit || node_dist == '0) ? S_HIT : S_RECIP;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_NODE_MUL;
                    end
                end
                S_HIT: begin
                    // point on a node: one-hot weights
                    r_wr_en   <= 1'b1;
                    r_wr_axis <= r_axis;
                    r_wr_addr <= r_i;
                    r_wr_data <= (r_i == r_hit_idx) ? cbb_pkg::ONE_Q28 : '0;
                    if (r_i == r_d) begin
                        r_i <= '0;
                        if (!r_axis) begin
                            r_axis  <= 1'b1;
                            r_state <= S_AXIS;
                        end else begin
                            r_j     <= '0;
                            r_state <= S_READ;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_RECIP: begin
                    r_div_req.start <= 1'b1;
                    r_div_req.rem0  <= '0;
                    r_div_req.den   <= 64'(mdist);
                    r_div_req.low   <= recip_end ? (59'd1 << 57) : (59'd1 << 58);
                    r_div_req.count <= cbb_pkg::RECIP_STEPS;
                    r_state         <= S_RECIP_WAIT;
                end
                S_RECIP_WAIT: begin
                    if (div_rsp.done) begin
                        r_q[r_i] <= qval;
                        r_sum    <= r_sum + 64'(qval);
                        if (r_i == r_d) begin
                            r_i     <= '0;
                            r_state <= S_WEIGHT;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RECIP;
                        end
                    end
                end
                S_WEIGHT: begin
                    if (r_sum == '0 || cur_q == '0 || 64'(mq >> 20) >= msum) begin
                        // vanishing sum or zero term gives zero; quotient too large saturates
                        r_wr_en   <= 1'b1;
                        r_wr_axis <= r_axis;
                        r_wr_addr <= r_i;
                        if (r_sum == '0 || cur_q == '0) begin
                            r_wr_data <= '0;
                        end else begin
                            r_wr_data <= wneg ? $signed(48'(-wcap)) : $signed(wcap);
                        end
                        if (r_i == r_d) begin
                            r_i <= '0;
                            if (!r_axis) begin
                                r_axis  <= 1'b1;
                                r_state <= S_AXIS;
                            end else begin
                                r_j     <= '0;
                                r_state <= S_READ;
                            end
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_div_req.start <= 1'b1;
                        r_div_req.rem0  <= 64'(mq >> 20);
                        r_div_req.den   <= msum;
                        r_div_req.low   <= {mq[19:0], 39'b0};
                        r_div_req.count <= cbb_pkg::WEIGHT_STEPS;
                        r_state         <= S_WEIGHT_WAIT;
                    end
                end
                S_WEIGHT_WAIT: begin
                    if (div_rsp.done) begin
                        r_wr_en   <= 1'b1;
                        r_wr_axis <= r_axis;
                        r_wr_addr <= r_i;
                        r_wr_data <= wneg ? $signed(48'(-wq)) : $signed(wq);
                        if (r_i == r_d) begin
                            r_i <= '0;
                            if (!r_axis) begin
                                r_axis  <= 1'b1;
                                r_state <= S_AXIS;
                            end else begin
                                r_j     <= '0;
                                r_state <= S_READ;
                            end
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_WEIGHT;
                        end
                    end
                end
                S_READ: begin
                    // store read data lands at the end of this cycle; hold here while
                    // the last weight write is still landing
                    if (!r_wr_en) begin
                        r_state <= S_MUL_LO;
                    end
                end
                S_MUL_LO: begin
                    r_plo   <= 72'(ma) * 72'(mb[23:0]);
                    r_pneg  <= r_xw_rd[47] ^ r_ew_rd[47];
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    r_phi   <= 72'(ma) * 72'(mb[47:24]);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_out_value <= r_pneg ? $signed(48'(-pmag)) : $signed(pmag);
                    r_out_xi    <= r_i;
                    r_out_eta   <= r_j;
                    r_out_last  <= (r_i == r_d) && (r_j == r_d);
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            if (r_j == r_d) begin
                                r_j <= '0;
                                r_i <= r_i + 1'b1;
                            end else begin
                                r_j <= r_j + 1'b1;
                            end
                            r_state <= S_READ;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_basis_value = r_out_value;
    assign o_xi_node     = r_out_xi;
    assign o_eta_node    = r_out_eta;
    assign o_last        = r_out_last;

endmodule

// File: design/cbb_chk.sv
module cbb_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input logic signed [47:0] o_basis_value,
    input logic [2:0]         o_xi_node,
    input logic [2:0]         o_eta_node,
    input logic               o_last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_basis_value)
        && $stable(o_xi_node) && $stable(o_eta_node) && $stable(o_last))
        else $error("stalled result changed");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while a result is pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after an accepted item");

    a_last_square: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_xi_node == o_eta_node)
        else $error("last result not on the diagonal corner");

endmodule

bind chebyshev_barycentric_basis_2d_core cbb_chk u_cbb_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_basis_value (o_basis_value),
    .o_xi_node     (o_xi_node),
    .o_eta_node    (o_eta_node),
    .o_last        (o_last)
);
